// ----- rtl/core/text_console_char_writer_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the text console character writer
// Shared property wrappers, clocked on the rising edge and muted in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcw assertion failed");

// next-cycle implication
`define TCW_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcw assertion failed");

`endif

// ----- rtl/core/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Constants, codes and types shared by the text console writer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int COLUMNS     = 64;
   localparam int ROWS        = 32;
   localparam int PAGES       = 8;
   localparam int COL_W       = 6;
   localparam int ROW_W       = 5;
   localparam int LINE_W      = 8;
   localparam int ADDR_W      = LINE_W + COL_W;
   localparam int STORE_CELLS = COLUMNS * ROWS * PAGES;
   localparam int MAX_TOP     = (PAGES - 1) * ROWS;
   localparam int TAB_STOP    = 4;
   localparam int CNT_W       = 3;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // operations of the shared cursor unit
   localparam logic [1:0] OP_ADV = 2'd0;
   localparam logic [1:0] OP_NL  = 2'd1;
   localparam logic [1:0] OP_BS  = 2'd2;

   typedef struct packed {
      logic [LINE_W-1:0] top;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } pos_type;

   typedef struct packed {
      pos_type nxt;
      logic    scrolled;
   } step_type;

endpackage

// ----- rtl/core/text_console_char_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer
// Character-cell console: paged text store, cursor and scroll offset.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per beat: write a character, clear, or read one
//   visible cell. rsp_* returns exactly one beat per command with the cursor,
//   the top line of the view, a redraw flag and the cell read.
//   A command is taken only while the sequencer is idle; the shared cursor
//   unit handles one cell per cycle.
//   Printable, newline and backspace take one cursor step, a tab one step per
//   padding cell (1 to 4 cells), a read one store read; clear zeroes one store
//   cell per cycle.
//   The next command can be accepted the cycle after the result is loaded.
//   After reset the whole store is swept to zero with req_tready low.
//   A stalled receiver holds the result in the output register; a finished
//   item then waits in its final step until the register frees, while the
//   next command is still accepted once the sequencer is back to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_char_writer_macros.svh"

module text_console_char_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], read_row[12:8], read_col[18:13]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // cursor_col[5:0], cursor_row[10:6], top_line[18:11],
                                    // scrolled[19], cell_char[27:20]
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_DONE  = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;

   localparam int AW = tcw_pkg::ADDR_W;

   logic [2:0]                  state_ff, state_in;
   tcw_pkg::pos_type            pos_ff, pos_in;
   logic [1:0]                  op_ff, op_in;
   logic [7:0]                  char_ff, char_in;
   logic [tcw_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        scr_ff, scr_in;
   logic                        rd_sel_ff, rd_sel_in;
   logic [tcw_pkg::ROW_W-1:0]   rrow_ff, rrow_in;
   logic [tcw_pkg::COL_W-1:0]   rcol_ff, rcol_in;
   logic [AW-1:0]               clr_ptr_ff, clr_ptr_in;
   logic                        clr_rsp_ff, clr_rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [31:0]                 rsp_data_ff, rsp_data_in;

   logic [7:0]                  store [tcw_pkg::STORE_CELLS];
   logic [7:0]                  rd_data_ff;
   logic                        mem_we;
   logic                        mem_re;
   logic [AW-1:0]               mem_addr;
   logic [7:0]                  mem_wdata;

   tcw_pkg::step_type           step;
   tcw_pkg::pos_type            wr_pos;
   logic                        req_fire;
   logic                        rsp_load;
   logic [1:0]                  req_cmd;
   logic [7:0]                  req_char;

   assign req_cmd  = req_tuser;
   assign req_char = req_tdata[7:0];
   assign req_tready = state_ff == ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   tcw_cursor_unit u_cursor (
      .op  (op_ff),
      .cur (pos_ff),
      .res (step)
   );

   // backspace stores under the cursor after the step back
   assign wr_pos = (op_ff == tcw_pkg::OP_BS) ? step.nxt : pos_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = {wr_pos.top + tcw_pkg::LINE_W'(wr_pos.row), wr_pos.col};
      mem_wdata = char_ff;
      unique case (state_ff)
         ST_EXEC: begin
            mem_we = 1'b1;
         end
         ST_READ: begin
            mem_re   = 1'b1;
            mem_addr = {pos_ff.top + tcw_pkg::LINE_W'(rrow_ff), rcol_ff};
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ptr_ff;
            mem_wdata = tcw_pkg::CH_NUL;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store[mem_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      op_in        = op_ff;
      char_in      = char_ff;
      cnt_in       = cnt_ff;
      scr_in       = scr_ff;
      rd_sel_in    = rd_sel_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      clr_ptr_in   = clr_ptr_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               scr_in    = 1'b0;
               rd_sel_in = 1'b0;
               unique case (req_cmd)
                  tcw_pkg::CMD_WRITE: begin
                     state_in = ST_EXEC;
                     cnt_in   = tcw_pkg::CNT_W'(1);
                     char_in  = req_char;
                     op_in    = tcw_pkg::OP_ADV;
                     case (req_char)
                        tcw_pkg::CH_NL: begin
                           op_in = tcw_pkg::OP_NL;
                        end
                        tcw_pkg::CH_BS: begin
                           op_in   = tcw_pkg::OP_BS;
                           char_in = tcw_pkg::CH_NUL;
                        end
                        tcw_pkg::CH_TAB: begin
                           // pad up to the next tab stop from the start column
                           char_in = tcw_pkg::CH_SPACE;
                           cnt_in  = tcw_pkg::CNT_W'(tcw_pkg::TAB_STOP)
                                   - {1'b0, pos_ff.col[1:0]};
                        end
                        default: begin
                           op_in = tcw_pkg::OP_ADV;
                        end
                     endcase
                  end
                  tcw_pkg::CMD_CLEAR: begin
                     state_in   = ST_CLEAR;
                     pos_in     = '0;
                     scr_in     = 1'b1;
                     clr_ptr_in = '0;
                     clr_rsp_in = 1'b1;
                  end
                  tcw_pkg::CMD_READ: begin
                     state_in  = ST_READ;
                     rd_sel_in = 1'b1;
                     rrow_in   = req_tdata[12:8];
                     rcol_in   = req_tdata[18:13];
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_EXEC: begin
            pos_in = step.nxt;
            scr_in = scr_ff | step.scrolled;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == tcw_pkg::CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_CLEAR: begin
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == AW'(tcw_pkg::STORE_CELLS - 1)) begin
               state_in   = clr_rsp_ff ? ST_DONE : ST_IDLE;
               clr_rsp_in = 1'b0;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000,
                               rd_sel_ff ? rd_data_ff : tcw_pkg::CH_NUL,
                               scr_ff,
                               pos_ff.top,
                               pos_ff.row,
                               pos_ff.col};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pos_ff       <= '0;
         clr_ptr_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         op_ff        <= tcw_pkg::OP_ADV;
         scr_ff       <= 1'b0;
         rd_sel_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         clr_ptr_ff   <= clr_ptr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         op_ff        <= op_in;
         scr_ff       <= scr_in;
         rd_sel_ff    <= rd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      rrow_ff     <= rrow_in;
      rcol_ff     <= rcol_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `TCW_ASSERT_IMP(a_row_in_screen, clock, reset, 1'b1,
      pos_ff.row <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1))
   `TCW_ASSERT_IMP(a_top_in_store, clock, reset, 1'b1,
      pos_ff.top <= tcw_pkg::LINE_W'(tcw_pkg::MAX_TOP))
   `TCW_ASSERT_IMP(a_exec_has_count, clock, reset, state_ff == ST_EXEC,
      cnt_ff != '0 && cnt_ff <= tcw_pkg::CNT_W'(tcw_pkg::TAB_STOP))
   `TCW_ASSERT_NXT(a_load_sets_valid, clock, reset, rsp_load,
      rsp_tvalid && state_ff == ST_IDLE)
   `TCW_ASSERT_IMP(a_no_write_when_reading, clock, reset, mem_re, !mem_we)

endmodule

// ----- rtl/core/tcw_cursor_unit.sv -----
// ----------------------------------------------------------------------------
// tcw_cursor_unit
// Shared cursor arithmetic: advance with wrap/scroll, newline and backspace.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_cursor_unit (
   input  logic [1:0]       op,
   input  tcw_pkg::pos_type cur,
   output tcw_pkg::step_type res
);

   logic can_scroll;
   logic last_col;
   logic last_row;

   assign can_scroll = cur.top < tcw_pkg::LINE_W'(tcw_pkg::MAX_TOP);
   assign last_col   = cur.col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
   assign last_row   = cur.row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

   always_comb begin
      res.nxt      = cur;
      res.scrolled = 1'b0;
      unique case (op)
         tcw_pkg::OP_ADV: begin
            if (last_col) begin
               res.nxt.col = '0;
               if (last_row) begin
                  // stay on the bottom row; view moves only while lines remain
                  if (can_scroll) begin
                     res.nxt.top  = cur.top + 1'b1;
                     res.scrolled = 1'b1;
                  end
               end else begin
                  res.nxt.row = cur.row + 1'b1;
               end
            end else begin
               res.nxt.col = cur.col + 1'b1;
            end
         end
         tcw_pkg::OP_NL: begin
            if (can_scroll) begin
               res.nxt.col = '0;
               if (last_row) begin
                  res.nxt.top  = cur.top + 1'b1;
                  res.scrolled = 1'b1;
               end else begin
                  res.nxt.row = cur.row + 1'b1;
               end
            end
         end
         tcw_pkg::OP_BS: begin
            if (cur.col == '0) begin
               if (cur.row != '0) begin
                  res.nxt.col = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
                  res.nxt.row = cur.row - 1'b1;
               end
            end else begin
               res.nxt.col = cur.col - 1'b1;
            end
         end
         default: begin
            res.nxt      = cur;
            res.scrolled = 1'b0;
         end
      endcase
   end

endmodule

// ----- bench/text_console_char_writer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_checker
// Watches both stream channels of the console writer. Every accepted command
// beat is run through a local model of the console (text store, cursor and
// view) and the predicted view is queued; every accepted result beat is
// compared field by field against the oldest queued prediction.
// ----------------------------------------------------------------------------

module text_console_char_writer_checker
   import tcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], read_row[12:8], read_col[18:13]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // cursor_col[5:0], cursor_row[10:6], top_line[18:11],
                                    // scrolled[19], cell_char[27:20]
   output int          failures,
   output int          outstanding,
   output int          checked,
   output int          scroll_count,
   output int          deepest_top
);

   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic [7:0]        cell_char;
      logic              scrolled;
      logic [LINE_W-1:0] top_line;
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
   } console_view_type;

   logic [7:0]       text_cells [0:STORE_CELLS-1];
   int unsigned      col_pos;
   int unsigned      row_pos;
   int unsigned      top_pos;
   bit               redraw;
   console_view_type expected_views [$];
   console_view_type seen;
   console_view_type want;

   initial begin
      failures     = 0;
      outstanding  = 0;
      checked      = 0;
      scroll_count = 0;
      deepest_top  = 0;
   end

   task automatic report_mismatch(string what, int got, int wanted);
      failures++;
      if (failures <= PRINT_CAP) begin
         $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
                  $realtime, what, got, wanted, checked);
      end else if (failures == PRINT_CAP + 1) begin
         $display("[%0t] further mismatches counted but not printed", $realtime);
      end
   endtask

   function automatic void clear_console();
      foreach (text_cells[i]) text_cells[i] = CH_NUL;
      col_pos = 0;
      row_pos = 0;
      top_pos = 0;
   endfunction

   function automatic void store_cell(logic [7:0] ch);
      int unsigned idx;
      idx = (top_pos + row_pos) * COLUMNS + col_pos;
      if (idx < STORE_CELLS) text_cells[idx] = ch;
   endfunction

   // one column right; wrap, and scroll only while store lines remain below
   function automatic void step_right();
      col_pos++;
      if (col_pos > COLUMNS - 1) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos > ROWS - 1) begin
         row_pos = ROWS - 1;
         if (top_pos < MAX_TOP) begin
            top_pos++;
            redraw = 1'b1;
         end
      end
   endfunction

   function automatic void put_char(logic [7:0] ch);
      int unsigned pad;
      case (ch)
         CH_NL: begin
            store_cell(ch);
            if (top_pos < MAX_TOP) begin
               col_pos = 0;
               if (row_pos >= ROWS - 1) begin
                  row_pos = ROWS - 1;
                  top_pos++;
                  redraw = 1'b1;
               end else begin
                  row_pos++;
               end
            end
         end
         CH_BS: begin
            if (col_pos == 0) begin
               if (row_pos > 0) begin
                  col_pos = COLUMNS - 1;
                  row_pos--;
               end
            end else begin
               col_pos--;
            end
            store_cell(CH_NUL);
         end
         CH_TAB: begin
            pad = ((col_pos + TAB_STOP) & ~(TAB_STOP - 1)) - col_pos;
            repeat (pad) begin
               store_cell(CH_SPACE);
               step_right();
            end
         end
         default: begin
            store_cell(ch);
            step_right();
         end
      endcase
   endfunction

   function automatic console_view_type predict_view(logic [1:0] cmd, logic [7:0] ch,
                                                     logic [4:0] rrow, logic [5:0] rcol);
      console_view_type view;
      int unsigned      idx;
      logic [7:0]       rd_char;
      rd_char = CH_NUL;
      redraw  = 1'b0;
      case (cmd)
         CMD_WRITE: put_char(ch);
         CMD_CLEAR: begin
            clear_console();
            redraw = 1'b1;
         end
         CMD_READ: begin
            if (rrow < ROWS && rcol < COLUMNS) begin
               idx = (top_pos + rrow) * COLUMNS + rcol;
               if (idx < STORE_CELLS) rd_char = text_cells[idx];
            end
         end
         default: ;
      endcase
      view.cursor_col = col_pos[COL_W-1:0];
      view.cursor_row = row_pos[ROW_W-1:0];
      view.top_line   = top_pos[LINE_W-1:0];
      view.scrolled   = redraw;
      view.cell_char  = rd_char;
      return view;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_console();
         expected_views.delete();
      end else begin
         // result first: a command accepted at this edge cannot be answered yet
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[27:0];
            if (expected_views.size() == 0) begin
               report_mismatch("result beat with nothing outstanding", int'(rsp_tdata), 0);
            end else begin
               want = expected_views.pop_front();
               if (seen.cursor_col !== want.cursor_col)
                  report_mismatch("cursor_col", int'(seen.cursor_col),
                                  int'(want.cursor_col));
               if (seen.cursor_row !== want.cursor_row)
                  report_mismatch("cursor_row", int'(seen.cursor_row),
                                  int'(want.cursor_row));
               if (seen.top_line !== want.top_line)
                  report_mismatch("top_line", int'(seen.top_line), int'(want.top_line));
               if (seen.scrolled !== want.scrolled)
                  report_mismatch("scrolled", int'(seen.scrolled), int'(want.scrolled));
               if (seen.cell_char !== want.cell_char)
                  report_mismatch("cell_char", int'(seen.cell_char),
                                  int'(want.cell_char));
               if (rsp_tdata[31:28] !== 4'd0)
                  report_mismatch("tdata padding", int'(rsp_tdata[31:28]), 0);
               checked++;
               if (want.scrolled) scroll_count++;
               if (want.top_line > deepest_top) deepest_top = want.top_line;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_views.push_back(predict_view(req_tuser, req_tdata[7:0],
                                                  req_tdata[12:8], req_tdata[18:13]));
         end
      end
      outstanding <= expected_views.size();
   end

endmodule

// ----- bench/text_console_char_writer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_tb
// Stimulus and verdict for the console writer. A short directed run covers
// byte extremes, tab, backspace and newline corners and every command; then
// random text, a newline-heavy stretch that drives the view to the bottom of
// the store, and text written there once scrolling is no longer possible.
// ----------------------------------------------------------------------------

module text_console_char_writer_tb;
   import tcw_pkg::*;

   localparam logic [1:0] CMD_SPARE   = 2'd3;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         DRAIN_TAIL  = 20;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // char_code[7:0], read_row[12:8], read_col[18:13]
   logic [1:0]  req_tuser  = CMD_WRITE;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // cursor_col[5:0], cursor_row[10:6], top_line[18:11],
                                   // scrolled[19], cell_char[27:20]

   int failures;
   int outstanding;
   int checked;
   int scroll_count;
   int deepest_top;

   int cycle_count = 0;
   bit quiet_tail  = 1'b0;
   int rx_stall    = 0;
   int rx_calm     = 0;
   int tx_calm     = 0;
   int n_write     = 0;
   int n_clear     = 0;
   int n_read      = 0;
   int n_spare     = 0;
   int nl_sent     = 0;
   int bs_sent     = 0;

   text_console_char_writer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   text_console_char_writer_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .failures     (failures),
      .outstanding  (outstanding),
      .checked      (checked),
      .scroll_count (scroll_count),
      .deepest_top  (deepest_top)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[%0t] run stopped at cycle limit, %0d results outstanding",
                  $realtime, outstanding);
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random stall bursts, with calm stretches in between
   always @(posedge clock) begin
      if (quiet_tail) begin
         rx_stall = 0;
         rsp_tready <= 1'b1;
      end else if (rx_stall > 0) begin
         rx_stall--;
         if (rx_stall == 0) rsp_tready <= 1'b1;
      end else if (rx_calm > 0) begin
         rx_calm--;
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 10) begin
         rx_stall = $urandom_range(1, 13);
         rsp_tready <= 1'b0;
      end else begin
         if ($urandom_range(0, 99) < 2) rx_calm = $urandom_range(30, 150);
         rsp_tready <= 1'b1;
      end
   end

   task automatic sender_gap();
      int gap;
      if (quiet_tail) return;
      if (tx_calm > 0) begin
         tx_calm--;
      end else if ($urandom_range(0, 99) < 20) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else if ($urandom_range(0, 99) < 3) begin
         tx_calm = $urandom_range(10, 40);
      end
   endtask

   task automatic send_cmd(logic [1:0] cmd, logic [7:0] ch, logic [4:0] rrow,
                           logic [5:0] rcol);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'd0, rcol, rrow, ch};
      do @(posedge clock); while (!req_tready);
      case (cmd)
         CMD_WRITE: n_write++;
         CMD_CLEAR: n_clear++;
         CMD_READ:  n_read++;
         default:   n_spare++;
      endcase
      sender_gap();
   endtask

   task automatic put(logic [7:0] ch);
      send_cmd(CMD_WRITE, ch, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
   endtask

   // random command; nl_pct biases writes towards newline
   task automatic send_random(int nl_pct, int read_pct);
      logic [1:0] cmd;
      logic [7:0] ch;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < read_pct)          cmd = CMD_READ;
      else if (pick < read_pct + 2) cmd = CMD_SPARE;
      else                          cmd = CMD_WRITE;
      pick = $urandom_range(0, 99);
      if (pick < nl_pct)            ch = CH_NL;
      else if (pick < nl_pct + 4)   ch = CH_BS;
      else if (pick < nl_pct + 14)  ch = CH_TAB;
      else                          ch = 8'($urandom_range(0, 255));
      if (cmd == CMD_WRITE && ch == CH_NL) nl_sent++;
      if (cmd == CMD_WRITE && ch == CH_BS) bs_sent++;
      send_cmd(cmd, ch, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
   endtask

   // hold off until every outstanding result beat has been seen
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int clear_at;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_cmd(CMD_READ, 8'hFF, 5'd0, 6'd0);
      put(8'h41);
      put(8'hFF);
      put(CH_NUL);
      put(8'h01);
      put(CH_TAB);            // on a tab stop: four spaces
      put(8'h78);
      put(CH_TAB);            // three spaces
      put(CH_BS);
      put(CH_BS);
      put(CH_NL);
      put(CH_BS);             // column 0: back to the end of the row above
      put(8'h7E);             // last column, wraps to the next row
      send_cmd(CMD_READ, 8'h00, 5'd0, 6'd63);
      send_cmd(CMD_READ, 8'h00, 5'd0, 6'd0);
      send_cmd(CMD_SPARE, 8'hFF, 5'd31, 6'd63);
      send_cmd(CMD_CLEAR, 8'h00, 5'd0, 6'd0);
      put(CH_BS);             // home position: stays put
      put(CH_TAB);
      send_cmd(CMD_READ, 8'h55, 5'd31, 6'd63);
      send_cmd(CMD_READ, 8'hAA, 5'd0, 6'd1);

      // mixed text with one clear somewhere in the middle
      clear_at = $urandom_range(15, 45);
      for (int i = 0; i < 60; i++) begin
         if (i == clear_at)
            send_cmd(CMD_CLEAR, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                     6'($urandom_range(0, 63)));
         else
            send_random(6, 15);
      end

      drain();
      send_cmd(CMD_CLEAR, 8'h00, 5'd0, 6'd0);

      // newline-heavy: row + top line grows by at least one per newline net of
      // backspaces, so this ends with the view at the bottom of the store
      nl_sent = 0;
      bs_sent = 0;
      while (nl_sent - bs_sent < (ROWS - 1) + MAX_TOP + 3) send_random(88, 5);

      // no more scrolling: wraps and newlines stay on the last row
      for (int i = 0; i < 60; i++) begin
         if (i == 20) quiet_tail = 1'b1;
         send_random(5, 20);
      end

      drain();
      repeat (DRAIN_TAIL) @(posedge clock);
      $display("Commands: %0d writes, %0d clears, %0d reads, %0d spare; %0d results checked",
               n_write, n_clear, n_read, n_spare, checked);
      $display("Results with redraw: %0d, deepest top line reached: %0d",
               scroll_count, deepest_top);
      if (failures == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- text_console_char_writer.f -----
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_cursor_unit.sv
rtl/core/text_console_char_writer.sv
bench/text_console_char_writer_checker.sv
bench/text_console_char_writer_tb.sv
